// File: hdl/cfdr_pkg.sv
`timescale 1ns / 1ps

package cfdr_pkg;

  localparam int ByteW = 8;
  localparam int PixelW = 16;
  localparam int WidthW = 16;
  localparam int FrameNumW = 16;
  localparam int CfgIndexW = 2;
  localparam int OutDataW = 40;

  localparam logic [ByteW-1:0] SyncFill = 8'hFF;
  localparam logic [ByteW-1:0] SyncMark = 8'h01;
  localparam logic [1:0] SyncRunFull = 2'd3;
  localparam logic [2:0] HeaderLast = 3'd4;

  localparam logic [ByteW-1:0] LineCountReset = 8'd48;
  localparam logic [ByteW-1:0] LinePrefixReset = 8'd12;
  localparam logic [ByteW-1:0] TrailerReset = 8'd6;
  localparam logic [WidthW-1:0] FrameWidthReset = 16'd128;

  localparam logic [CfgIndexW-1:0] RegLineCount = 2'd0;
  localparam logic [CfgIndexW-1:0] RegLinePrefix = 2'd1;
  localparam logic [CfgIndexW-1:0] RegTrailer = 2'd2;

  typedef struct packed {
    logic [ByteW-1:0] line_count;
    logic [ByteW-1:0] line_prefix_bytes;
    logic [ByteW-1:0] trailer_bytes;
  } cfg_t;

  typedef struct packed {
    logic [FrameNumW-1:0] frame_number;
    logic [ByteW-1:0] packet_format;
    logic frame_end;
    logic line_end;
    logic [PixelW-1:0] pixel_rgb565;
  } result_t;

  function automatic logic [PixelW-1:0] gray_to_rgb565(input logic [ByteW-1:0] g);
    gray_to_rgb565 = {g[7:3], g[7:2], g[7:3]};
  endfunction

endpackage

// File: hdl/cfdr_parser.sv
`timescale 1ns / 1ps

module cfdr_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             stream_byte,
  input  cfdr_pkg::cfg_t         cfg,
  output logic                   emit,
  output cfdr_pkg::result_t      result
);
  import cfdr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PREFIX,
    PH_PIXELS,
    PH_TRAILER
  } phase_t;

  phase_t               phase, phase_next;
  logic [1:0]           sync_run, sync_run_next;
  logic [2:0]           header_index, header_index_next;
  logic [WidthW-1:0]    frame_width, frame_width_next;
  logic [ByteW-1:0]     line_index, line_index_next;
  logic [WidthW-1:0]    byte_index, byte_index_next;
  logic [ByteW-1:0]     format_id, format_id_next;
  logic [FrameNumW-1:0] frame_counter, frame_counter_next;

  logic [WidthW-1:0]    byte_inc;
  logic [ByteW-1:0]     line_inc;
  logic                 line_end, frame_end;

  function automatic phase_t line_start(input logic [WidthW-1:0] w,
                                        input logic [ByteW-1:0] li,
                                        input cfg_t c);
    if (w == '0 || li >= c.line_count) begin
      line_start = (c.trailer_bytes != '0) ? PH_TRAILER : PH_HUNT;
    end else if (c.line_prefix_bytes != '0) begin
      line_start = PH_PREFIX;
    end else begin
      line_start = PH_PIXELS;
    end
  endfunction

  assign byte_inc = byte_index + WidthW'(1);
  assign line_inc = line_index + ByteW'(1);

  always_comb begin
    phase_next = phase;
    sync_run_next = sync_run;
    header_index_next = header_index;
    frame_width_next = frame_width;
    line_index_next = line_index;
    byte_index_next = byte_index;
    format_id_next = format_id;
    frame_counter_next = frame_counter;
    line_end = 1'b0;
    frame_end = 1'b0;
    unique case (phase)
      PH_HUNT: begin
        if (stream_byte == SyncFill) begin
          if (sync_run != SyncRunFull) begin
            sync_run_next = sync_run + 2'd1;
          end
        end else if (stream_byte == SyncMark && sync_run == SyncRunFull) begin
          sync_run_next = '0;
          header_index_next = '0;
          phase_next = PH_HEADER;
        end else begin
          sync_run_next = '0;
        end
      end
      PH_HEADER: begin
        if (header_index == 3'd0) begin
          format_id_next = stream_byte;
        end else if (header_index == 3'd1) begin
          frame_width_next = {frame_width[15:8], stream_byte};
        end else if (header_index == 3'd2) begin
          frame_width_next = {stream_byte, frame_width[7:0]};
        end
        if (header_index >= HeaderLast) begin
          header_index_next = '0;
          frame_counter_next = frame_counter + FrameNumW'(1);
          line_index_next = '0;
          byte_index_next = '0;
          sync_run_next = '0;
          phase_next = line_start(frame_width, '0, cfg);
        end else begin
          header_index_next = header_index + 3'd1;
        end
      end
      PH_PREFIX: begin
        if (byte_inc >= {8'd0, cfg.line_prefix_bytes}) begin
          byte_index_next = '0;
          phase_next = PH_PIXELS;
        end else begin
          byte_index_next = byte_inc;
        end
      end
      PH_PIXELS: begin
        if (byte_inc >= frame_width) begin
          line_end = 1'b1;
          frame_end = (line_inc >= cfg.line_count);
          line_index_next = line_inc;
          byte_index_next = '0;
          sync_run_next = '0;
          phase_next = line_start(frame_width, line_inc, cfg);
        end else begin
          byte_index_next = byte_inc;
        end
      end
      PH_TRAILER: begin
        if (byte_inc >= {8'd0, cfg.trailer_bytes}) begin
          byte_index_next = '0;
          sync_run_next = '0;
          phase_next = PH_HUNT;
        end else begin
          byte_index_next = byte_inc;
        end
      end
      default: begin
        byte_index_next = '0;
        sync_run_next = '0;
        phase_next = PH_HUNT;
      end
    endcase
  end

  assign emit = (phase == PH_PIXELS);
  assign result.pixel_rgb565 = gray_to_rgb565(stream_byte);
  assign result.line_end = line_end;
  assign result.frame_end = frame_end;
  assign result.packet_format = format_id;
  assign result.frame_number = frame_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      sync_run <= '0;
      header_index <= '0;
      frame_width <= FrameWidthReset;
      line_index <= '0;
      byte_index <= '0;
      format_id <= '0;
      frame_counter <= '0;
    end else if (step) begin
      phase <= phase_next;
      sync_run <= sync_run_next;
      header_index <= header_index_next;
      frame_width <= frame_width_next;
      line_index <= line_index_next;
      byte_index <= byte_index_next;
      format_id <= format_id_next;
      frame_counter <= frame_counter_next;
    end
  end

endmodule

// File: hdl/cfdr_out_reg.sv
`timescale 1ns / 1ps

module cfdr_out_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  cfdr_pkg::result_t             result,
  output logic                          ready,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [cfdr_pkg::OutDataW-1:0] m_tdata,
  output logic                          m_tlast,
  output logic                          m_tuser
);
  import cfdr_pkg::*;

  result_t held;

  assign ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign m_tdata = {held.frame_number, held.packet_format, held.pixel_rgb565};
  assign m_tlast = held.line_end;
  assign m_tuser = held.frame_end;

endmodule

// File: hdl/camera_frame_deframer_rgb565_core.sv
`timescale 1ns / 1ps

// Deframes a camera byte stream: it hunts for three or more 0xFF bytes followed by 0x01,
// reads a five-byte header (data id, width, height), and then for each configured line
// skips the line prefix and turns each gray byte into one RGB565 pixel transaction, with
// tlast on the last pixel of a line and tuser on the last pixel of a frame. One byte is
// taken every clock cycle while the output does not stall; a byte passes through an input
// register and the parser into the output register, which offers its pixel. Backpressure
// stalls input only when a pixel byte waits and the output register is full and not drained.
module camera_frame_deframer_rgb565_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [cfdr_pkg::ByteW-1:0]     s_tdata,   // stream_byte
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [cfdr_pkg::OutDataW-1:0]  m_tdata,   // pixel_rgb565, packet_format, frame_number
  output logic                           m_tlast,   // line_end
  output logic                           m_tuser,   // frame_end
  input  logic                           cfg_we,
  input  logic [cfdr_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [cfdr_pkg::ByteW-1:0]     cfg_data
);
  import cfdr_pkg::*;

  cfg_t             cfg;
  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             emit;
  logic             out_ready;
  logic             advance;
  result_t          result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_count <= LineCountReset;
      cfg.line_prefix_bytes <= LinePrefixReset;
      cfg.trailer_bytes <= TrailerReset;
    end else if (cfg_we) begin
      if (cfg_index == RegLineCount) begin
        cfg.line_count <= cfg_data;
      end else if (cfg_index == RegLinePrefix) begin
        cfg.line_prefix_bytes <= cfg_data;
      end else if (cfg_index == RegTrailer) begin
        cfg.trailer_bytes <= cfg_data;
      end
    end
  end

  assign advance = in_valid && (!emit || out_ready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  cfdr_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .stream_byte (in_byte),
    .cfg         (cfg),
    .emit        (emit),
    .result      (result)
  );

  cfdr_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && emit),
    .result   (result),
    .ready    (out_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  a_frame_end_on_line_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tuser || m_tlast))
    else $error("frame end without line end");

  a_input_captured: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> in_valid)
    else $error("accepted byte not held in input register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !(advance && emit))
    else $error("pending pixel overwritten");

endmodule
